FILE: src/flvtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FLV tag deframer package
// Shared widths, phase codes, register indexes and the result beat type.
// -----------------------------------------------------------------------------
package flvtd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 24;
  localparam int unsigned StampW = 32;
  localparam int unsigned ClassW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PhFile    = 3'd0;
  localparam logic [PhaseW-1:0] PhTagHdr  = 3'd1;
  localparam logic [PhaseW-1:0] PhPayload = 3'd2;
  localparam logic [PhaseW-1:0] PhTrailer = 3'd3;
  localparam logic [PhaseW-1:0] PhDead    = 3'd4;

  localparam logic [CfgIdxW-1:0] RegAudio   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegVideo   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMeta    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMetaAlt = 2'd3;

  localparam logic [ByteW-1:0] AudioCodeRst   = 8'd8;
  localparam logic [ByteW-1:0] VideoCodeRst   = 8'd9;
  localparam logic [ByteW-1:0] MetaCodeRst    = 8'd18;
  localparam logic [ByteW-1:0] MetaAltCodeRst = 8'd15;

  localparam logic [ClassW-1:0] ClsAudio = 2'd0;
  localparam logic [ClassW-1:0] ClsVideo = 2'd1;
  localparam logic [ClassW-1:0] ClsMeta  = 2'd2;

  localparam logic [ByteW-1:0] SigF      = 8'h46;
  localparam logic [ByteW-1:0] SigL      = 8'h4C;
  localparam logic [ByteW-1:0] SigV      = 8'h56;
  localparam logic [ByteW-1:0] HdrOffset = 8'h09;
  localparam int unsigned      AudioBit  = 2;
  localparam int unsigned      VideoBit  = 0;

  localparam logic [SizeW-1:0] FileHdrLast = 24'd12;
  localparam logic [SizeW-1:0] TagHdrLast  = 24'd10;
  localparam logic [SizeW-1:0] TrailerLast = 24'd3;

  typedef struct packed {
    logic [ByteW-1:0] audio;
    logic [ByteW-1:0] video;
    logic [ByteW-1:0] meta;
    logic [ByteW-1:0] meta_alt;
  } codes_t;

  typedef struct packed {
    logic              header_error;
    logic [ByteW-1:0]  payload_byte;
    logic [ClassW-1:0] tag_class;
    logic [SizeW-1:0]  tag_size;
    logic [StampW-1:0] timestamp;
    logic              first_of_tag;
    logic              last_of_tag;
    logic              has_audio;
    logic              has_video;
  } res_t;

endpackage
`default_nettype wire

FILE: src/flvtd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FLV tag deframer channels
// Input byte channel and result channel, valid/ready handshake.
// -----------------------------------------------------------------------------
interface flvtd_in_if;
  logic                        valid;
  logic                        ready;
  logic [flvtd_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface flvtd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         header_error;
  logic [flvtd_pkg::ByteW-1:0]  payload_byte;
  logic [flvtd_pkg::ClassW-1:0] tag_class;
  logic [flvtd_pkg::SizeW-1:0]  tag_size;
  logic [flvtd_pkg::StampW-1:0] timestamp;
  logic                         first_of_tag;
  logic                         last_of_tag;
  logic                         has_audio;
  logic                         has_video;

  modport source (
    output valid, output header_error, output payload_byte, output tag_class,
    output tag_size, output timestamp, output first_of_tag, output last_of_tag,
    output has_audio, output has_video, input ready
  );
  modport sink (
    input valid, input header_error, input payload_byte, input tag_class,
    input tag_size, input timestamp, input first_of_tag, input last_of_tag,
    input has_audio, input has_video, output ready
  );
endinterface
`default_nettype wire

FILE: src/flvtd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FLV tag deframer parser
// Phase and count registers; one byte per step gives the next state and at
// most one result beat.
// -----------------------------------------------------------------------------
module flvtd_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [flvtd_pkg::ByteW-1:0] byte_i,
  input  wire flvtd_pkg::codes_t           codes_i,
  output logic                             res_valid_o,
  output flvtd_pkg::res_t                  res_o
);

  logic [flvtd_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [flvtd_pkg::SizeW-1:0]  cnt_q, cnt_d;
  logic [flvtd_pkg::ByteW-1:0]  type_q, type_d;
  logic [flvtd_pkg::SizeW-1:0]  size_q, size_d;
  logic [flvtd_pkg::StampW-1:0] stamp_q, stamp_d;
  logic                         bad_q, bad_d;
  logic                         audio_q, audio_d;
  logic                         video_q, video_d;

  logic [flvtd_pkg::SizeW-1:0]  cnt_inc;
  logic [flvtd_pkg::SizeW:0]    cnt_next_w;
  logic                         is_last;
  logic                         cls_hit;
  logic [flvtd_pkg::ClassW-1:0] cls;

  assign cnt_inc    = cnt_q + 1'b1;
  assign cnt_next_w = {1'b0, cnt_q} + 1'b1;
  assign is_last    = (cnt_next_w >= {1'b0, size_q});

  always_comb begin
    cls_hit = 1'b1;
    cls     = flvtd_pkg::ClsAudio;
    if (type_q == codes_i.audio) begin
      cls = flvtd_pkg::ClsAudio;
    end else if (type_q == codes_i.video) begin
      cls = flvtd_pkg::ClsVideo;
    end else if (type_q == codes_i.meta || type_q == codes_i.meta_alt) begin
      cls = flvtd_pkg::ClsMeta;
    end else begin
      cls_hit = 1'b0;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    type_d      = type_q;
    size_d      = size_q;
    stamp_d     = stamp_q;
    bad_d       = bad_q;
    audio_d     = audio_q;
    video_d     = video_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      flvtd_pkg::PhFile: begin
        case (cnt_q)
          24'd0: if (byte_i != flvtd_pkg::SigF) bad_d = 1'b1;
          24'd1: if (byte_i != flvtd_pkg::SigL) bad_d = 1'b1;
          24'd2: if (byte_i != flvtd_pkg::SigV) bad_d = 1'b1;
          24'd4: begin
            audio_d = byte_i[flvtd_pkg::AudioBit];
            video_d = byte_i[flvtd_pkg::VideoBit];
          end
          24'd5, 24'd6, 24'd7: if (byte_i != '0) bad_d = 1'b1;
          24'd8: if (byte_i != flvtd_pkg::HdrOffset) bad_d = 1'b1;
          default: ;
        endcase
        if (cnt_q >= flvtd_pkg::FileHdrLast) begin
          cnt_d = '0;
          if (bad_q) begin
            phase_d            = flvtd_pkg::PhDead;
            res_valid_o        = 1'b1;
            res_o.header_error = 1'b1;
          end else begin
            phase_d = flvtd_pkg::PhTagHdr;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end

      flvtd_pkg::PhTagHdr: begin
        case (cnt_q)
          24'd0: type_d = byte_i;
          24'd1: size_d[23:16] = byte_i;
          24'd2: size_d[15:8] = byte_i;
          24'd3: size_d[7:0] = byte_i;
          24'd4: stamp_d[23:16] = byte_i;
          24'd5: stamp_d[15:8] = byte_i;
          24'd6: stamp_d[7:0] = byte_i;
          24'd7: stamp_d[31:24] = byte_i;
          default: ;
        endcase
        if (cnt_q >= flvtd_pkg::TagHdrLast) begin
          cnt_d   = '0;
          phase_d = (size_q == '0) ? flvtd_pkg::PhTrailer : flvtd_pkg::PhPayload;
        end else begin
          cnt_d = cnt_inc;
        end
      end

      flvtd_pkg::PhPayload: begin
        if (is_last) begin
          cnt_d   = '0;
          phase_d = flvtd_pkg::PhTrailer;
        end else begin
          cnt_d = cnt_inc;
        end
        res_valid_o        = cls_hit;
        res_o.payload_byte = byte_i;
        res_o.tag_class    = cls;
        res_o.tag_size     = size_q;
        res_o.timestamp    = stamp_q;
        res_o.first_of_tag = (cnt_q == '0);
        res_o.last_of_tag  = is_last;
        res_o.has_audio    = audio_q;
        res_o.has_video    = video_q;
      end

      flvtd_pkg::PhTrailer: begin
        if (cnt_q >= flvtd_pkg::TrailerLast) begin
          cnt_d   = '0;
          phase_d = flvtd_pkg::PhTagHdr;
        end else begin
          cnt_d = cnt_inc;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= flvtd_pkg::PhFile;
      cnt_q   <= '0;
      type_q  <= '0;
      size_q  <= '0;
      stamp_q <= '0;
      bad_q   <= 1'b0;
      audio_q <= 1'b0;
      video_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      size_q  <= size_d;
      stamp_q <= stamp_d;
      bad_q   <= bad_d;
      audio_q <= audio_d;
      video_q <= video_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/flv_tag_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FLV tag deframer core
// Checks the file header, parses tag headers and passes on payload bytes of
// audio, video and metadata tags with their tag attributes.
// -----------------------------------------------------------------------------
// channel   dir  beat                       notes
// in_i      in   one raw stream byte        valid/ready
// out_o     out  one payload or error beat  valid/ready, registered
// cfg       in   register write             we/idx/data, no back-pressure
//
// One byte per cycle; a result is in the output register the cycle after its
// byte is taken. A byte is taken while the output register is empty or being
// drained in the same cycle. Reset restarts the file header check and restores
// the default tag codes.
// After a header error, bytes are still taken and dropped.
// -----------------------------------------------------------------------------
module flv_tag_deframer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  flvtd_in_if.sink                           in_i,
  flvtd_out_if.source                        out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [flvtd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [flvtd_pkg::ByteW-1:0]   cfg_data_i
);

  flvtd_pkg::codes_t codes_q;
  flvtd_pkg::res_t   res;
  flvtd_pkg::res_t   res_q;
  logic              res_valid;
  logic              out_valid_q;
  logic              step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.audio    <= flvtd_pkg::AudioCodeRst;
      codes_q.video    <= flvtd_pkg::VideoCodeRst;
      codes_q.meta     <= flvtd_pkg::MetaCodeRst;
      codes_q.meta_alt <= flvtd_pkg::MetaAltCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        flvtd_pkg::RegAudio:   codes_q.audio    <= cfg_data_i;
        flvtd_pkg::RegVideo:   codes_q.video    <= cfg_data_i;
        flvtd_pkg::RegMeta:    codes_q.meta     <= cfg_data_i;
        flvtd_pkg::RegMetaAlt: codes_q.meta_alt <= cfg_data_i;
        default: ;
      endcase
    end
  end

  flvtd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_i.in_byte),
    .codes_i     (codes_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.header_error = res_q.header_error;
  assign out_o.payload_byte = res_q.payload_byte;
  assign out_o.tag_class    = res_q.tag_class;
  assign out_o.tag_size     = res_q.tag_size;
  assign out_o.timestamp    = res_q.timestamp;
  assign out_o.first_of_tag = res_q.first_of_tag;
  assign out_o.last_of_tag  = res_q.last_of_tag;
  assign out_o.has_audio    = res_q.has_audio;
  assign out_o.has_video    = res_q.has_video;

endmodule
`default_nettype wire

FILE: src/flvtd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FLV tag deframer checker
// Port-level checks on the result channel, bound to the core.
// -----------------------------------------------------------------------------
module flvtd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic                         header_error_i,
  input wire logic [flvtd_pkg::ByteW-1:0]  payload_byte_i,
  input wire logic [flvtd_pkg::ClassW-1:0] tag_class_i,
  input wire logic [flvtd_pkg::SizeW-1:0]  tag_size_i,
  input wire logic [flvtd_pkg::StampW-1:0] timestamp_i,
  input wire logic                         first_of_tag_i,
  input wire logic                         last_of_tag_i,
  input wire logic                         has_audio_i,
  input wire logic                         has_video_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i)
      && $stable(last_of_tag_i))
    else $error("result beat changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && header_error_i |-> payload_byte_i == '0 && tag_class_i == '0
      && tag_size_i == '0 && timestamp_i == '0 && !first_of_tag_i
      && !last_of_tag_i && !has_audio_i && !has_video_i)
    else $error("header error beat carries data");

  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && header_error_i |=> !out_valid_i)
    else $error("beat after header error");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !header_error_i && first_of_tag_i && tag_size_i == 24'd1
      |-> last_of_tag_i && tag_class_i != 2'd3)
    else $error("one-byte tag not marked last");

endmodule

bind flv_tag_deframer_core flvtd_checker u_flvtd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .header_error_i (out_o.header_error),
  .payload_byte_i (out_o.payload_byte),
  .tag_class_i    (out_o.tag_class),
  .tag_size_i     (out_o.tag_size),
  .timestamp_i    (out_o.timestamp),
  .first_of_tag_i (out_o.first_of_tag),
  .last_of_tag_i  (out_o.last_of_tag),
  .has_audio_i    (out_o.has_audio),
  .has_video_i    (out_o.has_video)
);
`default_nettype wire
